// ===== hw/rtl/mbfd_pkg.sv =====
// shared types, constants and the crc step for the battery frame decoder
package mbfd_pkg;

    // frame geometry
    localparam int FRAME_LEN = 59;
    localparam int CNT_W     = 6;
    localparam int NUM_CAPT  = 17;

    // header checks
    localparam logic [7:0]  FUNC_READ_HOLDING = 8'h03;
    localparam logic [7:0]  PAYLOAD_BYTES     = 8'h36;
    localparam logic [15:0] CRC_INIT          = 16'hFFFF;
    localparam logic [15:0] CRC_POLY          = 16'hA001;

    // header byte offsets
    localparam logic [CNT_W-1:0] OFF_FUNC  = CNT_W'(1);
    localparam logic [CNT_W-1:0] OFF_COUNT = CNT_W'(2);

    // byte offsets of the captured field bytes, in slot order
    localparam logic [CNT_W-1:0] CAPT_OFF [NUM_CAPT] = '{
        CNT_W'(3),  CNT_W'(17), CNT_W'(23), CNT_W'(24), CNT_W'(27), CNT_W'(28),
        CNT_W'(35), CNT_W'(36), CNT_W'(43), CNT_W'(49), CNT_W'(50), CNT_W'(51),
        CNT_W'(52), CNT_W'(53), CNT_W'(54), CNT_W'(55), CNT_W'(56)
    };

    // slot numbers of each decoded field (low byte for 16-bit fields)
    localparam int SLOT_TEMP_CELL   = 0;
    localparam int SLOT_TEMP_BOARD  = 1;
    localparam int SLOT_CURRENT     = 2;
    localparam int SLOT_CURRENT_TWO = 4;
    localparam int SLOT_PACK        = 6;
    localparam int SLOT_CHARGE      = 8;
    localparam int SLOT_CELL_ONE    = 9;
    localparam int SLOT_CELL_TWO    = 11;
    localparam int SLOT_CELL_THREE  = 13;
    localparam int SLOT_CELL_FOUR   = 15;

    // packed width of the result tdata
    localparam int OUT_W = 168;

    // one input beat
    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_start;
    } in_beat_t;

    // one decoded frame
    typedef struct packed {
        logic               frame_ok;
        logic [7:0]         charge_raw;
        logic signed [15:0] current_ma;
        logic signed [15:0] current_two_ma;
        logic [15:0]        pack_mv;
        logic [7:0]         temp_cell_c;
        logic [7:0]         temp_board_c;
        logic [15:0]        cell_one_mv;
        logic [15:0]        cell_two_mv;
        logic [15:0]        cell_three_mv;
        logic [15:0]        cell_four_mv;
        logic signed [31:0] power_uw;
    } result_t;

    // modbus crc-16 over one byte, reflected, lsb first
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// ===== hw/rtl/mbfd_in_stage.sv =====
// input register stage for incoming frame bytes
module mbfd_in_stage (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,
    input  logic [0:0]         s_tuser,
    input  logic               take,
    output logic               beat_valid,
    output mbfd_pkg::in_beat_t beat
);
    import mbfd_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    in_beat_t beat_reg;
    logic     accept;

    // room when empty or when the held beat leaves this cycle
    assign s_tready = !valid_reg || take;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        if (accept) begin
            valid_next = 1'b1;
        end else if (take) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // payload holds no reset
    always_ff @(posedge aclk) begin
        if (accept) begin
            beat_reg.data_byte   <= s_tdata;
            beat_reg.frame_start <= s_tuser[0];
        end
    end

    assign beat_valid = valid_reg;
    assign beat       = beat_reg;

endmodule

// ===== hw/rtl/mbfd_frame_core.sv =====
// byte counter, crc, header check, field capture and result decode
module mbfd_frame_core (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               beat_valid,
    input  mbfd_pkg::in_beat_t beat,
    input  logic               out_free,
    output logic               take,
    output logic               load,
    output mbfd_pkg::result_t  result
);
    import mbfd_pkg::*;

    logic [CNT_W-1:0] count_reg,  count_next;
    logic [15:0]      crc_reg,    crc_next;
    logic             header_reg, header_next;
    logic [7:0]       crc_low_reg;
    logic [7:0]       field_reg [NUM_CAPT];

    logic [CNT_W-1:0] cnt_base;
    logic [15:0]      crc_base;
    logic             header_base;
    logic             active;
    logic             last_byte;
    logic             update;
    logic [15:0]      pack_w;
    logic [15:0]      cur_w;
    logic signed [32:0] prod;

    // a new frame restarts count, crc and header from scratch
    assign cnt_base    = beat.frame_start ? '0 : count_reg;
    assign crc_base    = beat.frame_start ? CRC_INIT : crc_reg;
    assign header_base = beat.frame_start ? 1'b0 : header_reg;
    assign active      = cnt_base < CNT_W'(FRAME_LEN);
    assign last_byte   = active && (cnt_base == CNT_W'(FRAME_LEN - 1));

    // only the final byte needs space in the result register
    assign take   = beat_valid && (!last_byte || out_free);
    assign load   = take && last_byte;
    assign update = take && active;

    always_comb begin
        count_next  = cnt_base + CNT_W'(1);
        crc_next    = crc_base;
        header_next = header_base;
        if (cnt_base < CNT_W'(FRAME_LEN - 2)) begin
            crc_next = crc_byte(crc_base, beat.data_byte);
        end
        if (cnt_base == OFF_FUNC) begin
            header_next = (beat.data_byte == FUNC_READ_HOLDING);
        end
        if (cnt_base == OFF_COUNT) begin
            header_next = header_base && (beat.data_byte == PAYLOAD_BYTES);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= CNT_W'(FRAME_LEN);
            crc_reg    <= CRC_INIT;
            header_reg <= 1'b0;
        end else if (update) begin
            count_reg  <= count_next;
            crc_reg    <= crc_next;
            header_reg <= header_next;
        end
    end

    // field bytes and the crc low byte, each at its own offset
    always_ff @(posedge aclk) begin
        if (update) begin
            for (int k = 0; k < NUM_CAPT; k++) begin
                if (cnt_base == CAPT_OFF[k]) begin
                    field_reg[k] <= beat.data_byte;
                end
            end
            if (cnt_base == CNT_W'(FRAME_LEN - 2)) begin
                crc_low_reg <= beat.data_byte;
            end
        end
    end

    // decode from the captured bytes, little-endian pairs
    assign pack_w = {field_reg[SLOT_PACK + 1], field_reg[SLOT_PACK]};
    assign cur_w  = {field_reg[SLOT_CURRENT + 1], field_reg[SLOT_CURRENT]};
    assign prod   = $signed({1'b0, pack_w}) * $signed(cur_w);

    always_comb begin
        result.frame_ok       = header_base && (crc_base == {beat.data_byte, crc_low_reg});
        result.charge_raw     = field_reg[SLOT_CHARGE];
        result.current_ma     = $signed(cur_w);
        result.current_two_ma = $signed({field_reg[SLOT_CURRENT_TWO + 1],
                                         field_reg[SLOT_CURRENT_TWO]});
        result.pack_mv        = pack_w;
        result.temp_cell_c    = field_reg[SLOT_TEMP_CELL];
        result.temp_board_c   = field_reg[SLOT_TEMP_BOARD];
        result.cell_one_mv    = {field_reg[SLOT_CELL_ONE + 1], field_reg[SLOT_CELL_ONE]};
        result.cell_two_mv    = {field_reg[SLOT_CELL_TWO + 1], field_reg[SLOT_CELL_TWO]};
        result.cell_three_mv  = {field_reg[SLOT_CELL_THREE + 1], field_reg[SLOT_CELL_THREE]};
        result.cell_four_mv   = {field_reg[SLOT_CELL_FOUR + 1], field_reg[SLOT_CELL_FOUR]};
        result.power_uw       = $signed(prod[31:0]);
    end

endmodule

// ===== hw/rtl/mbfd_out_reg.sv =====
// result register on the master side
module mbfd_out_reg (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         load,
    input  mbfd_pkg::result_t            result,
    output logic                         out_free,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [mbfd_pkg::OUT_W-1:0]   m_tdata,
    output logic [0:0]                   m_tuser
);
    import mbfd_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    // free when empty or when the held beat is taken now
    assign out_free = !valid_reg || m_tready;

    always_comb begin
        if (load) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            result_reg <= result;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tuser  = result_reg.frame_ok;
    assign m_tdata  = {result_reg.power_uw,
                       result_reg.cell_four_mv,
                       result_reg.cell_three_mv,
                       result_reg.cell_two_mv,
                       result_reg.cell_one_mv,
                       result_reg.temp_board_c,
                       result_reg.temp_cell_c,
                       result_reg.pack_mv,
                       result_reg.current_two_ma,
                       result_reg.current_ma,
                       result_reg.charge_raw};

endmodule

// ===== hw/rtl/modbus_battery_frame_decoder_unit.sv =====
// top level of the modbus battery reply frame decoder
//
// Slave side takes one frame byte per beat: s_tdata is the byte, s_tuser
// flags the first byte of a new frame. A flagged byte drops any partial
// frame and restarts the byte count and the crc. Bytes arriving while no
// frame is open, or after a frame is complete, are taken and dropped.
// When the 59th byte of a frame is taken, one result beat is produced on
// the master side; m_tuser carries frame_ok (function code, byte count and
// little-endian crc all match), m_tdata carries the decoded fields, which
// are valid whether or not frame_ok is set.
// The final byte sits in the input register, then the decode loads the
// result register. Throughput is one byte per cycle unless a final byte
// waits on the output register; the crc byte update is eight unrolled
// shift and xor levels between the input register and the frame state.
// If the receiver stalls, the finished result holds in the output register
// and bytes keep flowing until the next frame's final byte, which waits in
// the input register until the output register frees.
// Reset (aresetn low, synchronous) empties both registers and leaves the
// block idle until a byte flagged as frame start arrives.
module modbus_battery_frame_decoder_unit (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [7:0]                 s_tdata,   // [7:0] data_byte
    input  logic [0:0]                 s_tuser,   // [0] frame_start
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // [7:0] charge_raw, [23:8] current_ma, [39:24] current_two_ma,
    // [55:40] pack_mv, [63:56] temp_cell_c, [71:64] temp_board_c,
    // [87:72] cell_one_mv, [103:88] cell_two_mv, [119:104] cell_three_mv,
    // [135:120] cell_four_mv, [167:136] power_uw
    output logic [mbfd_pkg::OUT_W-1:0] m_tdata,
    output logic [0:0]                 m_tuser    // [0] frame_ok
);
    import mbfd_pkg::*;

    logic     beat_valid;
    in_beat_t beat;
    logic     take;
    logic     load;
    logic     out_free;
    result_t  result;

    mbfd_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .take       (take),
        .beat_valid (beat_valid),
        .beat       (beat)
    );

    mbfd_frame_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .beat_valid (beat_valid),
        .beat       (beat),
        .out_free   (out_free),
        .take       (take),
        .load       (load),
        .result     (result)
    );

    mbfd_out_reg u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (load),
        .result   (result),
        .out_free (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

// ===== hw/rtl/mbfd_checker.sv =====
// port-level checks for the frame decoder, bound to the top level
module mbfd_checker (
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       s_tvalid,
    input logic                       s_tready,
    input logic [7:0]                 s_tdata,
    input logic [0:0]                 s_tuser,
    input logic                       m_tvalid,
    input logic                       m_tready,
    input logic [mbfd_pkg::OUT_W-1:0] m_tdata,
    input logic [0:0]                 m_tuser
);
    import mbfd_pkg::*;

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    // reset empties the result register
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // with an empty output register the byte side never stalls
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with output empty");

    // a frame start byte cannot itself produce a result
    a_start_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser[0] |=> ##1 !$rose(m_tvalid))
        else $error("result raised by a frame start byte");

endmodule

bind modbus_battery_frame_decoder_unit mbfd_checker u_mbfd_checker (.*);
